// ----- sv/vsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and constants of the video scroll address unit
// Request structs, command codes, access kinds and mirroring modes.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int unsigned ADDR_W = 15;
    localparam int unsigned PHYS_W = 14;

    typedef enum logic [3:0] {
        CMD_CTRL_WR   = 4'd0,
        CMD_SCROLL_WR = 4'd1,
        CMD_ADDR_WR   = 4'd2,
        CMD_DATA_RD   = 4'd3,
        CMD_DATA_WR   = 4'd4,
        CMD_STATUS_RD = 4'd5,
        CMD_FRAME_CPY = 4'd6,
        CMD_LINE_CPY  = 4'd7,
        CMD_X_INC     = 4'd8,
        CMD_Y_INC     = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } t_access;

    typedef enum logic [2:0] {
        MIR_HORIZONTAL = 3'd0,
        MIR_VERTICAL   = 3'd1,
        MIR_SINGLE_LO  = 3'd2,
        MIR_SINGLE_HI  = 3'd3,
        MIR_FOUR       = 3'd4
    } t_mirror;

    // Copy masks for the render-time steps
    localparam logic [ADDR_W-1:0] FRAME_CPY_MASK = 15'h7BE0;
    localparam logic [ADDR_W-1:0] LINE_CPY_MASK  = 15'h041F;
    localparam logic [4:0]        COARSE_Y_LAST  = 5'd29;
    localparam logic [4:0]        COARSE_MAX     = 5'd31;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] data_byte;
    } t_vsa_in;

    typedef struct packed {
        logic [1:0]        access_kind;
        logic [PHYS_W-1:0] physical_address;
        logic              pattern_space;
        logic [7:0]        write_byte;
        logic [ADDR_W-1:0] current_address;
        logic [2:0]        fine_scroll_x;
        logic              second_write;
    } t_vsa_out;

endpackage : vsa_pkg
`default_nettype wire

// ----- sv/vsa_addr_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_addr_map: physical address mapping
// Applies nametable and palette mirroring to the current video address.
// ----------------------------------------------------------------------------
module vsa_addr_map (
    input  wire logic [vsa_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [2:0]                 i_mode,
    output logic      [vsa_pkg::PHYS_W-1:0] o_phys,
    output logic                            o_pattern
);
    import vsa_pkg::*;

    logic [PHYS_W-1:0] a;
    logic [11:0]       off;

    assign a   = i_addr[PHYS_W-1:0];
    assign off = a[11:0];
    assign o_pattern = ~a[13];

    always_comb begin
        o_phys = a;
        if (!a[13]) begin
            o_phys = a;
        end else if (a[12:8] == 5'h1F) begin
            // palette: fold to 32 entries, backdrop aliases share entries with bit 4 clear
            o_phys = {a[13:8], 3'b000, (a[1:0] == 2'b00) ? 1'b0 : a[4], a[3:0]};
        end else begin
            unique case (i_mode)
                MIR_HORIZONTAL: o_phys = {3'b100, off[11], off[9:0]};
                MIR_VERTICAL:   o_phys = {3'b100, off[10:0]};
                MIR_SINGLE_LO:  o_phys = {4'b1000, off[9:0]};
                MIR_SINGLE_HI:  o_phys = {4'b1001, off[9:0]};
                default:        o_phys = {2'b10, off};
            endcase
        end
    end

endmodule : vsa_addr_map
`default_nettype wire

// ----- sv/video_scroll_address_unit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_scroll_address_unit_top: scroll and address registers
// Holds current/temporary video address, fine X, write toggle and step mode;
// executes one command per cycle unless stalled and reports the mapped access.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall| i_in_data  (t_vsa_in)
//  out      | output    | o_out_valid/ i_out_stall| o_out_data (t_vsa_out)
//  cfg      | input     | i_cfg_wr_en            | i_cfg_wr_data (mirroring)
//
// One request per cycle sustained unless stalled; each request passes the
// input register, then its result the output register. The input register
// feeds a single pass of command logic that updates the state and loads the
// result register in the same edge. Synchronous active-low reset clears valid
// flags and state, not payload. A stalled output holds the result; the input
// register still takes a new request while it waits, stalling when both fill.
// ----------------------------------------------------------------------------
module video_scroll_address_unit_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [2:0]        i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire vsa_pkg::t_vsa_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output vsa_pkg::t_vsa_out      o_out_data
);
    import vsa_pkg::*;

    // Request register stage
    logic    r_in_vld;
    t_vsa_in r_in;

    // Result register stage
    logic     r_out_vld;
    t_vsa_out r_out;

    // Architectural state
    logic [ADDR_W-1:0] r_cur, n_cur;
    logic [ADDR_W-1:0] r_tmp, n_tmp;
    logic [2:0]        r_fine_x, n_fine_x;
    logic              r_toggle, n_toggle;
    logic              r_step_row, n_step_row;
    logic [2:0]        r_mirror;

    logic     adv;
    t_vsa_out n_out;

    logic [PHYS_W-1:0] map_phys;
    logic              map_pat;
    logic [4:0]        coarse_y;
    logic [7:0]        d;

    // Advance the request into the result register when it is empty or drains
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;

    assign d        = r_in.data_byte;
    assign coarse_y = r_cur[9:5];

    vsa_addr_map u_map (
        .i_addr    (r_cur),
        .i_mode    (r_mirror),
        .o_phys    (map_phys),
        .o_pattern (map_pat)
    );

    always_comb begin
        n_cur      = r_cur;
        n_tmp      = r_tmp;
        n_fine_x   = r_fine_x;
        n_toggle   = r_toggle;
        n_step_row = r_step_row;
        n_out      = '0;
        unique case (r_in.cmd)
            CMD_CTRL_WR: begin
                n_tmp[11:10] = d[1:0];
                n_step_row   = d[2];
            end
            CMD_SCROLL_WR: begin
                if (!r_toggle) begin
                    n_tmp[4:0] = d[7:3];
                    n_fine_x   = d[2:0];
                end else begin
                    n_tmp[9:5]   = d[7:3];
                    n_tmp[14:12] = d[2:0];
                end
                n_toggle = ~r_toggle;
            end
            CMD_ADDR_WR: begin
                if (!r_toggle) begin
                    // high byte: bit 14 drops
                    n_tmp = {1'b0, d[5:0], r_tmp[7:0]};
                end else begin
                    n_tmp = {r_tmp[14:8], d};
                    n_cur = {r_tmp[14:8], d};
                end
                n_toggle = ~r_toggle;
            end
            CMD_DATA_RD, CMD_DATA_WR: begin
                n_out.access_kind      = (r_in.cmd == CMD_DATA_RD) ? ACC_READ : ACC_WRITE;
                n_out.physical_address = map_phys;
                n_out.pattern_space    = map_pat;
                n_out.write_byte       = (r_in.cmd == CMD_DATA_WR) ? d : 8'd0;
                n_cur = r_cur + (r_step_row ? ADDR_W'(32) : ADDR_W'(1));
            end
            CMD_STATUS_RD: begin
                n_toggle = 1'b0;
            end
            CMD_FRAME_CPY: begin
                n_cur = (r_cur & ~FRAME_CPY_MASK) | (r_tmp & FRAME_CPY_MASK);
            end
            CMD_LINE_CPY: begin
                n_cur = (r_cur & ~LINE_CPY_MASK) | (r_tmp & LINE_CPY_MASK);
            end
            CMD_X_INC: begin
                if (r_cur[4:0] == COARSE_MAX) begin
                    // wrap coarse X, hop to the neighbouring nametable
                    n_cur[4:0] = 5'd0;
                    n_cur[10]  = ~r_cur[10];
                end else begin
                    n_cur[4:0] = r_cur[4:0] + 5'd1;
                end
            end
            CMD_Y_INC: begin
                if (r_cur[14:12] != 3'd7) begin
                    n_cur[14:12] = r_cur[14:12] + 3'd1;
                end else begin
                    n_cur[14:12] = 3'd0;
                    if (coarse_y == COARSE_Y_LAST) begin
                        n_cur[9:5] = 5'd0;
                        n_cur[11]  = ~r_cur[11];
                    end else if (coarse_y == COARSE_MAX) begin
                        n_cur[9:5] = 5'd0;
                    end else begin
                        n_cur[9:5] = coarse_y + 5'd1;
                    end
                end
            end
            default: begin
                // unused command codes: hold everything
            end
        endcase
        n_out.current_address = n_cur;
        n_out.fine_scroll_x   = n_fine_x;
        n_out.second_write    = n_toggle;
    end

    // Control: valid flags and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_cur      <= '0;
            r_tmp      <= '0;
            r_fine_x   <= '0;
            r_toggle   <= 1'b0;
            r_step_row <= 1'b0;
            r_mirror   <= MIR_HORIZONTAL;
        end else begin
            if (i_cfg_wr_en) begin
                r_mirror <= i_cfg_wr_data;
            end
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld  <= 1'b1;
                r_cur      <= n_cur;
                r_tmp      <= n_tmp;
                r_fine_x   <= n_fine_x;
                r_toggle   <= n_toggle;
                r_step_row <= n_step_row;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule : video_scroll_address_unit_top
`default_nettype wire
